### sv/qau_pkg.sv
package qau_pkg;

   // component and accumulator widths
   localparam int COMP_W  = 32;
   localparam int QUAT_N  = 4;
   localparam int PROD_W  = 64;
   localparam int PAIR_W  = 65;
   localparam int ACC_W   = 66;
   localparam int SUMSQ_W = 65;
   localparam int ROOT_W  = 33;

   // action codes
   localparam logic [1:0] ACT_PROD = 2'd0;
   localparam logic [1:0] ACT_CONJ = 2'd1;
   localparam logic [1:0] ACT_NORM = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_SAT  = 2'd1;
   localparam logic [1:0] STAT_ZERO = 2'd2;

   localparam logic [COMP_W-1:0] COMP_MAX = 32'h7FFF_FFFF;
   localparam logic [COMP_W-1:0] COMP_MIN = 32'h8000_0000;

   typedef logic [COMP_W-1:0] comp_type;
   typedef comp_type [QUAT_N-1:0] quat_type;

   // per-stage pipeline control: advance enable and incoming valid
   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

   // side data that rides along the root and divide pipelines
   typedef struct packed {
      logic [1:0] action;
      quat_type   a;
      quat_type   prod;
      logic       prod_sat;
      logic       zero;
   } side_type;

endpackage

### sv/qau_mult.sv
module qau_mult import qau_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pipe_ctl_type         ctl,
   input  logic [1:0]           action,
   input  quat_type             a,
   input  quat_type             b,
   output logic                 out_valid,
   output logic [1:0]           out_action,
   output quat_type             out_a,
   output quat_type             out_prod,
   output logic                 out_sat,
   output logic [SUMSQ_W-1:0]   out_sumsq
);

   // stage 1: sixteen products; b is replaced by a for normalize so the
   // diagonal products become the squares
   quat_type                  bsel;
   logic signed [PROD_W-1:0]  p1_in [QUAT_N][QUAT_N];
   logic signed [PROD_W-1:0]  p1_ff [QUAT_N][QUAT_N];
   logic                      v1_ff;
   logic [1:0]                act1_ff;
   quat_type                  a1_ff;

   assign bsel = (action == ACT_NORM) ? a : b;

   always_comb begin
      for (int i = 0; i < QUAT_N; i++) begin
         for (int j = 0; j < QUAT_N; j++) begin
            p1_in[i][j] = $signed(a[i]) * $signed(bsel[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ctl.en) begin
         v1_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         act1_ff <= action;
         a1_ff   <= a;
         p1_ff   <= p1_in;
      end
   end

   // stage 2: pair sums of the Hamilton terms and of the squares
   logic signed [PAIR_W-1:0]  t2_in [QUAT_N][2];
   logic signed [PAIR_W-1:0]  t2_ff [QUAT_N][2];
   logic [PROD_W-1:0]         sq2_in [2];
   logic [PROD_W-1:0]         sq2_ff [2];
   logic                      v2_ff;
   logic [1:0]                act2_ff;
   quat_type                  a2_ff;

   always_comb begin
      t2_in[0][0] = PAIR_W'(p1_ff[0][3]) + PAIR_W'(p1_ff[1][2]);
      t2_in[0][1] = PAIR_W'(p1_ff[3][0]) - PAIR_W'(p1_ff[2][1]);
      t2_in[1][0] = PAIR_W'(p1_ff[1][3]) - PAIR_W'(p1_ff[0][2]);
      t2_in[1][1] = PAIR_W'(p1_ff[2][0]) + PAIR_W'(p1_ff[3][1]);
      t2_in[2][0] = PAIR_W'(p1_ff[0][1]) - PAIR_W'(p1_ff[1][0]);
      t2_in[2][1] = PAIR_W'(p1_ff[2][3]) + PAIR_W'(p1_ff[3][2]);
      t2_in[3][0] = PAIR_W'(p1_ff[3][3]) - PAIR_W'(p1_ff[0][0]);
      t2_in[3][1] = -PAIR_W'(p1_ff[1][1]) - PAIR_W'(p1_ff[2][2]);
      sq2_in[0]   = PROD_W'(p1_ff[0][0][PROD_W-2:0]) + PROD_W'(p1_ff[1][1][PROD_W-2:0]);
      sq2_in[1]   = PROD_W'(p1_ff[2][2][PROD_W-2:0]) + PROD_W'(p1_ff[3][3][PROD_W-2:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ctl.en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         act2_ff <= act1_ff;
         a2_ff   <= a1_ff;
         t2_ff   <= t2_in;
         sq2_ff  <= sq2_in;
      end
   end

   // stage 3: full-width sums
   logic signed [ACC_W-1:0]   acc3_in [QUAT_N];
   logic signed [ACC_W-1:0]   acc3_ff [QUAT_N];
   logic [SUMSQ_W-1:0]        sumsq3_in;
   logic [SUMSQ_W-1:0]        sumsq3_ff;
   logic                      v3_ff;
   logic [1:0]                act3_ff;
   quat_type                  a3_ff;

   always_comb begin
      for (int k = 0; k < QUAT_N; k++) begin
         acc3_in[k] = ACC_W'(t2_ff[k][0]) + ACC_W'(t2_ff[k][1]);
      end
      sumsq3_in = SUMSQ_W'(sq2_ff[0]) + SUMSQ_W'(sq2_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ctl.en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         act3_ff   <= act2_ff;
         a3_ff     <= a2_ff;
         acc3_ff   <= acc3_in;
         sumsq3_ff <= sumsq3_in;
      end
   end

   // stage 4: drop fraction bits and saturate
   logic signed [ACC_W-1:0]   sh4;
   logic                      fits4;
   quat_type                  prod4_in;
   logic                      sat4_in;
   quat_type                  prod4_ff;
   logic                      sat4_ff;
   logic [SUMSQ_W-1:0]        sumsq4_ff;
   logic                      v4_ff;
   logic [1:0]                act4_ff;
   quat_type                  a4_ff;

   always_comb begin
      sat4_in = 1'b0;
      sh4     = '0;
      fits4   = 1'b1;
      for (int k = 0; k < QUAT_N; k++) begin
         sh4   = acc3_ff[k] >>> FRACTION_BITS;
         fits4 = (sh4[ACC_W-1:COMP_W-1] == {(ACC_W-COMP_W+1){sh4[COMP_W-1]}});
         if (fits4) begin
            prod4_in[k] = sh4[COMP_W-1:0];
         end else begin
            prod4_in[k] = sh4[ACC_W-1] ? COMP_MIN : COMP_MAX;
            sat4_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (ctl.en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         act4_ff   <= act3_ff;
         a4_ff     <= a3_ff;
         prod4_ff  <= prod4_in;
         sat4_ff   <= sat4_in;
         sumsq4_ff <= sumsq3_ff;
      end
   end

   assign out_valid  = v4_ff;
   assign out_action = act4_ff;
   assign out_a      = a4_ff;
   assign out_prod   = prod4_ff;
   assign out_sat    = sat4_ff;
   assign out_sumsq  = sumsq4_ff;

endmodule

### sv/qau_sqrt.sv
module qau_sqrt import qau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  pipe_ctl_type         ctl,
   input  logic [SUMSQ_W-1:0]   sumsq,
   output logic                 out_valid,
   output logic [ROOT_W-1:0]    root
);

   localparam int TW = SUMSQ_W + 2;

   logic                 v_ff    [ROOT_W];
   logic [SUMSQ_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]    root_ff [ROOT_W];

   // one root bit per stage, most significant first
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;

      logic                 v_src;
      logic [SUMSQ_W-1:0]   rem_src;
      logic [ROOT_W-1:0]    root_src;
      logic [TW-1:0]        trial;
      logic                 take;
      logic [SUMSQ_W-1:0]   rem_in;
      logic [ROOT_W-1:0]    root_in;

      if (k == 0) begin : g_first
         assign v_src    = ctl.valid;
         assign rem_src  = sumsq;
         assign root_src = '0;
      end else begin : g_next
         assign v_src    = v_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
      assign trial   = (TW'(root_src) << (B + 1)) + (TW'(1) << (2 * B));
      assign take    = TW'(rem_src) >= trial;
      assign rem_in  = take ? (rem_src - trial[SUMSQ_W-1:0]) : rem_src;
      assign root_in = take ? (root_src | (ROOT_W'(1) << B)) : root_src;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (ctl.en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];

endmodule

### sv/qau_div.sv
module qau_div import qau_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pipe_ctl_type                  ctl,
   input  quat_type                      mag,
   input  logic [ROOT_W-1:0]             len,
   output logic                          out_valid,
   output logic [QUAT_N-1:0][FRACTION_BITS:0] quo
);

   localparam int QW = FRACTION_BITS + 1;
   localparam int RW = ROOT_W + 1;

   logic                 v_ff   [QW];
   logic [ROOT_W-1:0]    len_ff [QW];
   logic [ROOT_W-1:0]    rem_ff [QW][QUAT_N];
   logic [QW-1:0]        quo_ff [QW][QUAT_N];

   // one quotient bit per stage for all four lanes; magnitude never
   // exceeds the length, so the top bit is a plain compare
   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic                 v_src;
      logic [ROOT_W-1:0]    len_src;
      logic [RW-1:0]        part   [QUAT_N];
      logic [QW-1:0]        q_src  [QUAT_N];
      logic [RW-1:0]        diff   [QUAT_N];
      logic                 take   [QUAT_N];
      logic [ROOT_W-1:0]    rem_in [QUAT_N];
      logic [QW-1:0]        quo_in [QUAT_N];

      if (k == 0) begin : g_first
         assign v_src   = ctl.valid;
         assign len_src = len;
         for (genvar l = 0; l < QUAT_N; l++) begin : g_lane
            assign part[l]  = RW'(mag[l]);
            assign q_src[l] = '0;
         end
      end else begin : g_next
         assign v_src   = v_ff[k-1];
         assign len_src = len_ff[k-1];
         for (genvar l = 0; l < QUAT_N; l++) begin : g_lane
            assign part[l]  = {rem_ff[k-1][l], 1'b0};
            assign q_src[l] = quo_ff[k-1][l];
         end
      end

      always_comb begin
         for (int l = 0; l < QUAT_N; l++) begin
            diff[l]   = part[l] - RW'(len_src);
            take[l]   = part[l] >= RW'(len_src);
            rem_in[l] = take[l] ? diff[l][ROOT_W-1:0] : part[l][ROOT_W-1:0];
            quo_in[l] = {q_src[l][QW-2:0], take[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (ctl.en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.en) begin
            len_ff[k] <= len_src;
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign out_valid = v_ff[QW-1];

   always_comb begin
      for (int l = 0; l < QUAT_N; l++) begin
         quo[l] = quo_ff[QW-1][l];
      end
   end

endmodule

### sv/quaternion_arithmetic_unit.sv
// Stages from request to response:
//   4 multiply/sum stages, 33 square-root stages, FRACTION_BITS + 1 divide
//   stages and the output register. All actions take the same path.
// Throughput: one transaction per cycle; the whole pipeline advances when
//   the output register is empty or being taken.
// Reset: synchronous, active high; clears all stage valid bits.
module quaternion_arithmetic_unit import qau_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (32 bits each, lowest first)
   input  logic [255:0]  req_tdata,
   // action
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // r_x, r_y, r_z, r_w (32 bits each, lowest first)
   output logic [127:0]  rsp_tdata,
   // status
   output logic [1:0]    rsp_tuser
);

   localparam int QW = FRACTION_BITS + 1;

   logic          advance;
   logic          rsp_valid_ff;
   quat_type      rsp_r_ff;
   logic [1:0]    rsp_status_ff;
   logic [1:0]    rsp_act_ff;

   // global stall: every stage moves only when the output slot frees up
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // multiply and sum front end
   pipe_ctl_type        m_ctl;
   logic                m_valid;
   logic [1:0]          m_action;
   quat_type            m_a;
   quat_type            m_prod;
   logic                m_sat;
   logic [SUMSQ_W-1:0]  m_sumsq;

   assign m_ctl = '{en: advance, valid: req_tvalid};

   qau_mult #(.FRACTION_BITS(FRACTION_BITS)) u_mult (
      .clock      (clock),
      .reset      (reset),
      .ctl        (m_ctl),
      .action     (req_tuser),
      .a          (req_tdata[127:0]),
      .b          (req_tdata[255:128]),
      .out_valid  (m_valid),
      .out_action (m_action),
      .out_a      (m_a),
      .out_prod   (m_prod),
      .out_sat    (m_sat),
      .out_sumsq  (m_sumsq)
   );

   // length of a, for normalize
   pipe_ctl_type        s_ctl;
   logic                s_valid;
   logic [ROOT_W-1:0]   s_root;

   assign s_ctl = '{en: advance, valid: m_valid};

   qau_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ctl       (s_ctl),
      .sumsq     (m_sumsq),
      .out_valid (s_valid),
      .root      (s_root)
   );

   // side data delay matching the root pipeline
   side_type   side1_in;
   side_type   side1_ff [ROOT_W];

   assign side1_in = '{action: m_action, a: m_a, prod: m_prod, prod_sat: m_sat,
                       zero: (m_sumsq == '0)};

   always_ff @(posedge clock) begin
      if (advance) begin
         side1_ff[0] <= side1_in;
         for (int k = 1; k < ROOT_W; k++) begin
            side1_ff[k] <= side1_ff[k-1];
         end
      end
   end

   // magnitudes of a for the divider
   quat_type   d_mag;

   always_comb begin
      for (int l = 0; l < QUAT_N; l++) begin
         d_mag[l] = side1_ff[ROOT_W-1].a[l][COMP_W-1] ? (COMP_W'(0) - side1_ff[ROOT_W-1].a[l])
                                                     : side1_ff[ROOT_W-1].a[l];
      end
   end

   pipe_ctl_type                       d_ctl;
   logic                               d_valid;
   logic [QUAT_N-1:0][FRACTION_BITS:0] d_quo;

   assign d_ctl = '{en: advance, valid: s_valid};

   qau_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (d_ctl),
      .mag       (d_mag),
      .len       (s_root),
      .out_valid (d_valid),
      .quo       (d_quo)
   );

   // side data delay matching the divider
   side_type   side2_ff [QW];

   always_ff @(posedge clock) begin
      if (advance) begin
         side2_ff[0] <= side1_ff[ROOT_W-1];
         for (int k = 1; k < QW; k++) begin
            side2_ff[k] <= side2_ff[k-1];
         end
      end
   end

   // result select
   side_type   fin;
   quat_type   rsp_r_in;
   logic [1:0] rsp_status_in;

   assign fin = side2_ff[QW-1];

   always_comb begin
      rsp_r_in      = '0;
      rsp_status_in = STAT_OK;
      unique case (fin.action)
         ACT_PROD: begin
            rsp_r_in      = fin.prod;
            rsp_status_in = fin.prod_sat ? STAT_SAT : STAT_OK;
         end
         ACT_CONJ: begin
            for (int l = 0; l < QUAT_N - 1; l++) begin
               if (fin.a[l] == COMP_MIN) begin
                  rsp_r_in[l]   = COMP_MAX;
                  rsp_status_in = STAT_SAT;
               end else begin
                  rsp_r_in[l] = COMP_W'(0) - fin.a[l];
               end
            end
            rsp_r_in[QUAT_N-1] = fin.a[QUAT_N-1];
         end
         ACT_NORM: begin
            if (fin.zero) begin
               rsp_status_in = STAT_ZERO;
            end else begin
               for (int l = 0; l < QUAT_N; l++) begin
                  rsp_r_in[l] = fin.a[l][COMP_W-1] ? (COMP_W'(0) - COMP_W'(d_quo[l]))
                                                   : COMP_W'(d_quo[l]);
               end
            end
         end
         default: begin
            rsp_r_in      = '0;
            rsp_status_in = STAT_OK;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_r_ff      <= rsp_r_in;
         rsp_status_ff <= rsp_status_in;
         rsp_act_ff    <= fin.action;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_r_ff;
   assign rsp_tuser  = rsp_status_ff;

   // normalized components stay within one unit
   localparam logic signed [COMP_W-1:0] UNIT = COMP_W'(1) << FRACTION_BITS;
   logic norm_range_ok;

   always_comb begin
      norm_range_ok = 1'b1;
      for (int l = 0; l < QUAT_N; l++) begin
         if ($signed(rsp_r_ff[l]) > UNIT || $signed(rsp_r_ff[l]) < -UNIT) begin
            norm_range_ok = 1'b0;
         end
      end
   end

   a_norm_no_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_act_ff == ACT_NORM |-> rsp_status_ff != STAT_SAT)
      else $error("normalize reported saturation");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_act_ff == ACT_NORM && rsp_status_ff == STAT_OK |-> norm_range_ok)
      else $error("normalized component beyond unit length");

   a_zero_only_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STAT_ZERO |-> rsp_act_ff == ACT_NORM && rsp_r_ff == '0)
      else $error("zero-length status outside normalize");

endmodule

### verif/tb.sv
module tb;
   import qau_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = FRAC + 39;
   localparam int N_RANDOM = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [1:0] status;
      quat_type   r;
   } quat_result_type;

   // ordered store of predicted results and the checks against them
   class quat_scoreboard;
      quat_result_type pending[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function void note_request(quat_result_type exp_item);
         pending.push_back(exp_item);
      endfunction

      function void check_response(logic [127:0] data, logic [1:0] status);
         quat_result_type exp_item;
         string names[4];
         names = '{"r_x", "r_y", "r_z", "r_w"};
         if (pending.size() == 0) begin
            $error("response with nothing pending: data %h status %0d", data, status);
            errors++;
            return;
         end
         exp_item = pending.pop_front();
         for (int i = 0; i < 4; i++) begin
            if (data[32*i +: 32] !== exp_item.r[i]) begin
               $error("%s expected %h actual %h", names[i], exp_item.r[i], data[32*i +: 32]);
               errors++;
            end
         end
         if (status !== exp_item.status) begin
            $error("status expected %0d actual %0d", exp_item.status, status);
            errors++;
         end
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [255:0]  req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;

   quat_scoreboard board = new();
   int idle_cycles = 0;
   bit sink_stalls = 1'b1;

   always #4 clock = ~clock;

   quaternion_arithmetic_unit #(.FRACTION_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // clamp a wide signed value to 32 bits, raising the flag on clamp
   function automatic comp_type clamp32(logic signed [67:0] v, ref bit sat);
      if (v > 68'sh7FFF_FFFF) begin
         sat = 1'b1;
         return COMP_MAX;
      end
      if (v < -68'sh8000_0000) begin
         sat = 1'b1;
         return COMP_MIN;
      end
      return v[31:0];
   endfunction

   // integer square root, floor
   function automatic logic [32:0] floor_root(logic [65:0] s);
      logic [32:0] root;
      logic [32:0] trial;
      root = '0;
      for (int b = 32; b >= 0; b--) begin
         trial = root | (33'd1 << b);
         if ({33'd0, trial} * {33'd0, trial} <= s) root = trial;
      end
      return root;
   endfunction

   // predicted response for one quaternion operation
   function automatic quat_result_type quat_predict(logic [1:0] action, quat_type a,
                                                    quat_type b);
      quat_result_type res;
      logic signed [67:0] sa[4];
      logic signed [67:0] sb[4];
      logic signed [67:0] acc[4];
      logic [65:0] sumsq;
      logic [32:0] len;
      logic [67:0] mag;
      logic [67:0] quo;
      bit sat;
      sat = 1'b0;
      res = '0;
      for (int i = 0; i < 4; i++) begin
         sa[i] = $signed(a[i]);
         sb[i] = $signed(b[i]);
      end
      case (action)
         ACT_PROD: begin
            acc[0] = sa[0]*sb[3] + sa[1]*sb[2] - sa[2]*sb[1] + sa[3]*sb[0];
            acc[1] = -sa[0]*sb[2] + sa[1]*sb[3] + sa[2]*sb[0] + sa[3]*sb[1];
            acc[2] = sa[0]*sb[1] - sa[1]*sb[0] + sa[2]*sb[3] + sa[3]*sb[2];
            acc[3] = sa[3]*sb[3] - sa[0]*sb[0] - sa[1]*sb[1] - sa[2]*sb[2];
            for (int i = 0; i < 4; i++) res.r[i] = clamp32(acc[i] >>> FRAC, sat);
            res.status = sat ? STAT_SAT : STAT_OK;
         end
         ACT_CONJ: begin
            for (int i = 0; i < 3; i++) res.r[i] = clamp32(-sa[i], sat);
            res.r[3] = a[3];
            res.status = sat ? STAT_SAT : STAT_OK;
         end
         ACT_NORM: begin
            sumsq = '0;
            for (int i = 0; i < 4; i++) sumsq += 66'(sa[i] * sa[i]);
            if (sumsq == 0) begin
               res.status = STAT_ZERO;
            end else begin
               // a sum of 2^64 or more is taken as length 2^32
               len = sumsq[65:64] != 0 ? 33'h1_0000_0000 : floor_root(sumsq);
               for (int i = 0; i < 4; i++) begin
                  mag = sa[i] < 0 ? 68'(-sa[i]) : 68'(sa[i]);
                  quo = (mag << FRAC) / len;
                  res.r[i] = clamp32(sa[i] < 0 ? -$signed(quo) : $signed(quo), sat);
               end
               res.status = sat ? STAT_SAT : STAT_OK;
            end
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   // random gap: mostly short, now and then long
   function automatic int gap_length();
      int p;
      p = $urandom_range(99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic comp_type edge_comp();
      case ($urandom_range(7))
         0: return COMP_MAX;
         1: return COMP_MIN;
         2: return '0;
         3: return 32'h0001_0000;
         4: return 32'hFFFF_0000;
         5: return $urandom_range(32'h0004_0000);
         default: return $urandom();
      endcase
   endfunction

   // send one transaction and wait for its handshake; valid stays high
   task automatic send_request(logic [1:0] action, quat_type a, quat_type b);
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(quat_predict(action, a, b));
   endtask

   task automatic send_gap();
      int n;
      n = gap_length();
      if (n > 0) req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_random();
      quat_type a, b;
      logic [1:0] action;
      action = $urandom_range(10) == 0 ? ACT_NONE : 2'($urandom_range(2));
      for (int i = 0; i < 4; i++) begin
         a[i] = $urandom_range(1) ? edge_comp() : $urandom();
         b[i] = $urandom_range(1) ? edge_comp() : $urandom();
         if ($urandom_range(15) == 0) a[i] = '0;
      end
      send_request(action, a, b);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // response side: random stalls, with a stretch of none
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata, rsp_tuser);
         rsp_tready <= sink_stalls ? ($urandom_range(3) != 0 || $urandom_range(20) == 0 ?
                                      ($urandom_range(30) != 0) : 1'b0) : 1'b1;
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      quat_type a, b;
      quat_type zero_q;
      zero_q = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each action, zero length, unused code
      a = '{COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX};
      b = '{COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN};
      send_request(ACT_PROD, a, a);
      send_request(ACT_PROD, a, b);
      send_request(ACT_PROD, b, b);
      send_request(ACT_PROD, '{32'h0001_0000, 0, 0, 0}, '{32'h0001_0000, 0, 0, 0});
      send_request(ACT_PROD, '{32'h0002_8000, 32'hFFFF_0001, 5, 32'h0001_0000},
                   '{32'h0000_8000, 32'h0003_0000, 32'hFFFF_FFFF, 7});
      send_request(ACT_PROD, zero_q, b);
      send_request(ACT_CONJ, b, a);
      send_request(ACT_CONJ, a, b);
      send_request(ACT_CONJ, '{32'h1234_5678, 0, 32'hFFFF_FFFF, 1}, b);
      send_request(ACT_NORM, zero_q, a);
      send_request(ACT_NORM, a, zero_q);
      send_request(ACT_NORM, b, zero_q);
      send_request(ACT_NORM, '{0, 0, 0, 1}, zero_q);
      send_request(ACT_NORM, '{0, 0, 0, COMP_MIN}, zero_q);
      send_request(ACT_NORM, '{32'h0003_0000, 32'h0004_0000, 0, 0}, zero_q);
      send_request(ACT_NORM, '{1, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF}, zero_q);
      send_request(ACT_NONE, a, b);
      send_request(ACT_NONE, b, a);

      // hold off until the pipeline has drained
      wait_drained();

      // random, back to back at first, then with gaps
      sink_stalls = 1'b0;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 60) sink_stalls = 1'b1;
         if (i == 200) wait_drained();
         else if (i >= 60) send_gap();
         send_random();
      end

      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
